// File: hdl/kthl_pkg.sv
// Shared types and constants for the k-th largest selector.
`timescale 1ns / 1ps
package kthl_pkg;

   // Width of the rank register
   localparam int KSEL_W = 7;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_INSERT,
      OP_LOAD_REPLACE,
      OP_LOAD_SKIP,
      OP_READ_PARENT,
      OP_MOVE_UP,
      OP_READ_CHILD,
      OP_MOVE_DOWN,
      OP_PLACE
   } dp_op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_ADDR,
      ST_UP_CMP,
      ST_DN_ADDR,
      ST_DN_CMP,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type op;
      logic      emit;   // load result register and close the stream
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;      // heap holds k entries
      logic replace;   // incoming value beats the root
      logic pos_zero;  // hole is at the root
      logic up_stop;   // parent is not above the held value
      logic dn_leaf;   // hole has no child inside the heap
      logic dn_stop;   // held value is not above the smaller child
      logic last;      // item in work ends the stream
   } status_type;

endpackage

// File: hdl/kthl_ctrl.sv
// Controller state machine for the k-th largest selector.
`timescale 1ns / 1ps
module kthl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  kthl_pkg::status_type status,
   output kthl_pkg::cmd_type    cmd
);
   import kthl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.emit     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.full) begin
                  cmd.op   = OP_LOAD_INSERT;
                  state_in = ST_UP_ADDR;
               end else if (status.replace) begin
                  cmd.op   = OP_LOAD_REPLACE;
                  state_in = ST_DN_ADDR;
               end else begin
                  cmd.op   = OP_LOAD_SKIP;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_UP_ADDR: begin
            if (status.pos_zero) begin
               cmd.op   = OP_PLACE;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_READ_PARENT;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_stop) begin
               cmd.op   = OP_PLACE;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_MOVE_UP;
               state_in = ST_UP_ADDR;
            end
         end
         ST_DN_ADDR: begin
            if (status.dn_leaf) begin
               cmd.op   = OP_PLACE;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_READ_CHILD;
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (status.dn_stop) begin
               cmd.op   = OP_PLACE;
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_MOVE_DOWN;
               state_in = ST_DN_ADDR;
            end
         end
         ST_FINISH: begin
            // the last item of a stream holds here while a previous result is still waiting
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/kthl_datapath.sv
// Heap memory, hole registers, comparators and result register.
`timescale 1ns / 1ps
module kthl_datapath #(
   parameter int K_MAX       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [VALUE_WIDTH-1:0]      req_sample_value,
   input  logic                        req_end_of_set,
   input  logic                        csr_write,
   input  logic [kthl_pkg::KSEL_W-1:0] csr_k_select,
   input  kthl_pkg::cmd_type           cmd,
   output kthl_pkg::status_type        status,
   output logic [VALUE_WIDTH-1:0]      rsp_kth_value,
   output logic                        rsp_too_few
);
   import kthl_pkg::*;

   localparam int CNT_W  = $clog2(K_MAX + 1);
   localparam int ADDR_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int CW     = ADDR_W + 2;
   localparam int KW     = (CNT_W > KSEL_W) ? CNT_W : KSEL_W;

   logic [VALUE_WIDTH-1:0] heap_mem [K_MAX];

   logic [KSEL_W-1:0]      k_select_ff, k_select_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic                   last_ff, last_in;
   logic [VALUE_WIDTH-1:0] root_ff, root_in;
   logic [VALUE_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_too_few_ff, rsp_too_few_in;

   logic [KW-1:0]          k_ext;
   logic [CNT_W-1:0]       k_use;
   logic [CW-1:0]          k_cw, child0, child1;
   logic [ADDR_W-1:0]      parent_addr, child_addr, min_addr, rd_a_addr;
   logic                   sel_b;
   logic [VALUE_WIDTH-1:0] min_val;
   logic                   mem_we;
   logic [ADDR_W-1:0]      waddr;
   logic [VALUE_WIDTH-1:0] wdata;

   // Rank in use: zero acts as one, large values saturate
   always_comb begin
      k_ext = KW'(k_select_ff);
      if (k_ext == '0) begin
         k_use = CNT_W'(1);
      end else if (k_ext > KW'(K_MAX)) begin
         k_use = CNT_W'(K_MAX);
      end else begin
         k_use = k_ext[CNT_W-1:0];
      end
   end

   // Heap addressing around the hole
   assign k_cw        = CW'(k_use);
   assign child0      = {1'b0, pos_ff, 1'b1};
   assign child1      = child0 + CW'(1);
   assign parent_addr = (pos_ff - ADDR_W'(1)) >> 1;
   assign child_addr  = child0[ADDR_W-1:0];

   // Smaller child; the right one wins only when strictly smaller
   assign sel_b    = (child1 < k_cw) && ($signed(rd_b_ff) < $signed(rd_a_ff));
   assign min_val  = sel_b ? rd_b_ff : rd_a_ff;
   assign min_addr = sel_b ? child1[ADDR_W-1:0] : child_addr;

   // Status toward the controller
   assign status.full     = (fill_ff >= k_use);
   assign status.replace  = ($signed(req_sample_value) > $signed(root_ff));
   assign status.pos_zero = (pos_ff == '0);
   assign status.up_stop  = ($signed(rd_a_ff) <= $signed(x_ff));
   assign status.dn_leaf  = (child0 >= k_cw);
   assign status.dn_stop  = ($signed(x_ff) <= $signed(min_val));
   assign status.last     = last_ff;

   // Memory write port
   always_comb begin
      mem_we = 1'b0;
      waddr  = pos_ff;
      wdata  = x_ff;
      case (cmd.op)
         OP_PLACE: begin
            mem_we = 1'b1;
         end
         OP_MOVE_UP: begin
            mem_we = 1'b1;
            wdata  = rd_a_ff;
         end
         OP_MOVE_DOWN: begin
            mem_we = 1'b1;
            wdata  = min_val;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign rd_a_addr = (cmd.op == OP_READ_PARENT) ? parent_addr : child_addr;

   // Heap memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[waddr] <= wdata;
      end
      if (cmd.op == OP_READ_PARENT || cmd.op == OP_READ_CHILD) begin
         rd_a_ff <= heap_mem[rd_a_addr];
      end
      if (cmd.op == OP_READ_CHILD) begin
         rd_b_ff <= heap_mem[child1[ADDR_W-1:0]];
      end
   end

   // Next values of the working registers
   always_comb begin
      k_select_in    = k_select_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      x_in           = x_ff;
      last_in        = last_ff;
      root_in        = (mem_we && waddr == '0) ? wdata : root_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_too_few_in = rsp_too_few_ff;
      case (cmd.op)
         OP_LOAD_INSERT: begin
            x_in    = req_sample_value;
            last_in = req_end_of_set;
            pos_in  = fill_ff[ADDR_W-1:0];
            fill_in = fill_ff + CNT_W'(1);
         end
         OP_LOAD_REPLACE: begin
            x_in    = req_sample_value;
            last_in = req_end_of_set;
            pos_in  = '0;
         end
         OP_LOAD_SKIP: begin
            last_in = req_end_of_set;
         end
         OP_MOVE_UP: begin
            pos_in = parent_addr;
         end
         OP_MOVE_DOWN: begin
            pos_in = min_addr;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
      // Stream end: latch the answer and start a new stream
      if (cmd.emit) begin
         rsp_too_few_in = (fill_ff < k_use);
         rsp_value_in   = (fill_ff < k_use) ? '0 : root_ff;
         fill_in        = '0;
      end
      // A rank write abandons the current stream
      if (csr_write) begin
         k_select_in = csr_k_select;
         fill_in     = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_select_ff <= KSEL_W'(1);
         fill_ff     <= '0;
      end else begin
         k_select_ff <= k_select_in;
         fill_ff     <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      x_ff           <= x_in;
      last_ff        <= last_in;
      root_ff        <= root_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_too_few_ff <= rsp_too_few_in;
   end

   assign rsp_kth_value = rsp_value_ff;
   assign rsp_too_few   = rsp_too_few_ff;

endmodule

// File: hdl/kth_largest_min_heap_top.sv
// Top level of the streaming k-th largest selector.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_sample_value, req_end_of_set
//   rsp      out        rsp_valid/rsp_ready  rsp_kth_value, rsp_too_few
//   csr      in         csr_valid/csr_ready  csr_k_select
//
// One item at a time; a new item is taken only in the idle state. An item the heap
// keeps out goes straight to the final state; any other item moves through the heap
// one level per pass of the shared memory read/compare/write loop.
// The last item of a stream waits in its final state while the previous result
// is not yet taken.
// Synchronous reset sets the rank to 1 and empties the heap; no clearing pass.
`timescale 1ns / 1ps
module kth_largest_min_heap_top #(
   parameter int K_MAX       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [VALUE_WIDTH-1:0]      req_sample_value,
   input  logic                        req_end_of_set,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [VALUE_WIDTH-1:0]      rsp_kth_value,
   output logic                        rsp_too_few,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kthl_pkg::KSEL_W-1:0] csr_k_select
);
   import kthl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Rank writes are taken at any time
   assign csr_ready = 1'b1;

   kthl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kthl_datapath #(
      .K_MAX       (K_MAX),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_sample_value (req_sample_value),
      .req_end_of_set   (req_end_of_set),
      .csr_write        (csr_valid),
      .csr_k_select     (csr_k_select),
      .cmd              (cmd),
      .status           (status),
      .rsp_kth_value    (rsp_kth_value),
      .rsp_too_few      (rsp_too_few)
   );

endmodule
